FILE: hw/rtl/hkpe_pkg.sv
package hkpe_pkg;

  // Default fixed-point formats.
  localparam int COORD_FRAC_BITS_DEF = 24;
  localparam int OUT_FRAC_BITS_DEF   = 20;
  localparam int WAVE_FRAC           = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_WAVE_REAL = 2'd0;
  localparam logic [1:0] REG_WAVE_IMAG = 2'd1;

  // Reset values of the wave number: 10/(2*pi) and 1/(2*pi) in Q8.24.
  localparam logic [31:0] WAVE_REAL_RST = 32'd26701768;
  localparam logic [31:0] WAVE_IMAG_RST = 32'd2670177;

  // Arithmetic constants.
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] LOG2E_Q60      = 64'h171547652B82FE17;
  localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
  localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
  localparam logic [31:0] Q30_ONE        = 32'h4000_0000;

  // Series lengths.
  localparam int TRIG_TERMS = 5;
  localparam int EXP_TERMS  = 12;

  // Reciprocals ceil(2^39 / d): exact truncating division of any 31-bit value by d.
  localparam int RCP_SHIFT = 39;
  typedef logic [39:0] rcp_t;
  localparam rcp_t RCP_ONE = 40'd1 << RCP_SHIFT;

  // Sine series denominators 110, 72, 42, 20, 6.
  localparam rcp_t SIN_RCP [TRIG_TERMS] = '{
    (RCP_ONE + 40'd109) / 40'd110,
    (RCP_ONE + 40'd71) / 40'd72,
    (RCP_ONE + 40'd41) / 40'd42,
    (RCP_ONE + 40'd19) / 40'd20,
    (RCP_ONE + 40'd5) / 40'd6
  };

  // Cosine series denominators 90, 56, 30, 12, 2.
  localparam rcp_t COS_RCP [TRIG_TERMS] = '{
    (RCP_ONE + 40'd89) / 40'd90,
    (RCP_ONE + 40'd55) / 40'd56,
    (RCP_ONE + 40'd29) / 40'd30,
    (RCP_ONE + 40'd11) / 40'd12,
    (RCP_ONE + 40'd1) / 40'd2
  };

  // Exponential series denominators 12 down to 1.
  localparam rcp_t EXP_RCP [EXP_TERMS] = '{
    (RCP_ONE + 40'd11) / 40'd12,
    (RCP_ONE + 40'd10) / 40'd11,
    (RCP_ONE + 40'd9) / 40'd10,
    (RCP_ONE + 40'd8) / 40'd9,
    (RCP_ONE + 40'd7) / 40'd8,
    (RCP_ONE + 40'd6) / 40'd7,
    (RCP_ONE + 40'd5) / 40'd6,
    (RCP_ONE + 40'd4) / 40'd5,
    (RCP_ONE + 40'd3) / 40'd4,
    (RCP_ONE + 40'd2) / 40'd3,
    (RCP_ONE + 40'd1) / 40'd2,
    RCP_ONE
  };

endpackage

FILE: hw/rtl/helmholtz_kernel_pair_eval.sv
// Evaluates the 3D Helmholtz kernel exp(i*k*R)/R for one target/source point pair per item,
// with the complex wave number k taken from two configuration registers. The block is a
// fixed pipeline that accepts one item every clock cycle; its depth is set by the 33-step
// square root and the 63-step divider for the 1/R scaling. When the result is not taken,
// the whole pipeline holds. Coincident points return zero with the coincident flag set;
// parts that do not fit the Q12.20 output are clipped and flagged as saturated. Write the
// wave number only while the pipeline is empty.
module helmholtz_kernel_pair_eval
  import hkpe_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] source_x_i,
  input  logic signed [31:0] source_y_i,
  input  logic signed [31:0] source_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] real_part_o,
  output logic signed [31:0] imag_part_o,
  output logic               coincident_o,
  output logic               saturated_o
);

  localparam int FB        = WAVE_FRAC + COORD_FRAC_BITS;
  localparam int IP_W      = 128 - (FB + 60);
  localparam int E_W       = IP_W + 2;
  localparam int SH_W      = IP_W + 3;
  localparam int OUT_SHIFT = OUT_FRAC_BITS + COORD_FRAC_BITS - 60;
  localparam int RT_BITS   = 33;
  localparam int NUM_W     = 63;

  // Stage numbers.
  localparam int ST_DIF = 0;
  localparam int ST_SQR = 1;
  localparam int ST_SUM = 2;
  localparam int ST_RT0 = 3;
  localparam int ST_RTN = ST_RT0 + RT_BITS - 1;
  localparam int ST_MUL = ST_RTN + 1;
  localparam int ST_PP  = ST_MUL + 1;
  localparam int ST_TRN = ST_PP + 1;
  localparam int ST_ARG = ST_TRN + 1;
  localparam int ST_SQX = ST_ARG + 1;
  localparam int ST_HN0 = ST_SQX + 1;
  localparam int ST_HNN = ST_HN0 + 2 * EXP_TERMS - 1;
  localparam int ST_SIN = ST_HNN + 1;
  localparam int ST_NUM = ST_SIN + 1;
  localparam int ST_DV0 = ST_NUM + 1;
  localparam int ST_DVN = ST_DV0 + NUM_W - 1;
  localparam int ST_OUT = ST_DVN + 1;
  localparam int X2_END = ST_HN0 + 2 * TRIG_TERMS - 3;
  localparam int Y_END  = ST_HNN - 2;

  // Clipping and sign for one output part; returns {saturated, value}.
  function automatic logic [32:0] scale_part(logic [NUM_W-1:0] q,
                                             logic signed [SH_W-1:0] sh, logic neg);
    logic [31:0]      limit;
    logic [NUM_W-1:0] lim_w;
    logic [NUM_W-1:0] v;
    logic             sat;
    logic [SH_W-1:0]  nsh;
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    lim_w = NUM_W'(limit);
    sat   = 1'b0;
    v     = '0;
    nsh   = '0;
    if (q == '0) begin
      v = '0;
    end else if (sh < 0) begin
      nsh = SH_W'(-sh);
      if (nsh >= SH_W'(64)) v = '0;
      else v = q >> nsh[5:0];
      if (v > lim_w) begin
        sat = 1'b1;
        v   = lim_w;
      end
    end else if (sh >= SH_W'(63) || q > (lim_w >> sh[5:0])) begin
      sat = 1'b1;
      v   = lim_w;
    end else begin
      v = q << sh[5:0];
    end
    return {sat, neg ? 32'(-v[31:0]) : v[31:0]};
  endfunction

  // Absolute difference of two signed coordinates.
  function automatic logic [32:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic [31:0] wave_real_q, wave_imag_q;
  logic        adv;
  logic [ST_OUT:0] vld_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_real_q <= WAVE_REAL_RST;
      wave_imag_q <= WAVE_IMAG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_REAL: wave_real_q <= cfg_wdata_i;
        REG_WAVE_IMAG: wave_imag_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished item waits at the output.
  assign adv        = !vld_q[ST_OUT] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ST_OUT-1:0], in_valid_i};
    end
  end

  // Coordinate differences, squares and their sum.
  logic [32:0] dif_q [3];
  logic [65:0] sq_q [3];
  logic [65:0] sum_q;
  logic [65:0] sum_d;

  assign sum_d = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dif_q[0] <= abs_diff(target_x_i, source_x_i);
      dif_q[1] <= abs_diff(target_y_i, source_y_i);
      dif_q[2] <= abs_diff(target_z_i, source_z_i);
      for (int k = 0; k < 3; k++) sq_q[k] <= 66'(dif_q[k]) * 66'(dif_q[k]);
      sum_q <= sum_d;
    end
  end

  // Square root, one result bit per stage.
  logic [66:0] rt_rem_q [ST_RT0:ST_RTN];
  logic [32:0] rt_res_q [ST_RT0:ST_RTN];

  for (genvar i = 0; i < RT_BITS; i++) begin : g_sqrt
    localparam int B = RT_BITS - 1 - i;
    logic [66:0] rem_in, trial;
    logic [32:0] res_in;
    if (i == 0) begin : g_first
      assign rem_in = {1'b0, sum_q};
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rt_rem_q[ST_RT0+i-1];
      assign res_in = rt_res_q[ST_RT0+i-1];
    end
    assign trial = (67'(res_in) << (B + 1)) | (67'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rt_rem_q[ST_RT0+i] <= rem_in - trial;
          rt_res_q[ST_RT0+i] <= res_in | (33'd1 << B);
        end else begin
          rt_rem_q[ST_RT0+i] <= rem_in;
          rt_res_q[ST_RT0+i] <= res_in;
        end
      end
    end
  end

  // Phase and decay arguments: |k|*R, then times 1/(2*pi) and log2(e) as partial products.
  logic [31:0]  kr_mag, ki_mag;
  logic [64:0]  pk_full, pm_full;
  logic [63:0]  pk_q, pm_q;
  logic [63:0]  ppk_q [4];
  logic [63:0]  ppm_q [4];
  logic [127:0] prod_k, prod_m;
  logic [31:0]  turn_q, fr_q;
  logic [IP_W-1:0] ip_q;

  assign kr_mag  = wave_real_q[31] ? 32'(-wave_real_q) : wave_real_q;
  assign ki_mag  = wave_imag_q[31] ? 32'(-wave_imag_q) : wave_imag_q;
  assign pk_full = 65'(kr_mag) * 65'(rt_res_q[ST_RTN]);
  assign pm_full = 65'(ki_mag) * 65'(rt_res_q[ST_RTN]);

  assign prod_k = {64'd0, ppk_q[0]} + {32'd0, ppk_q[1], 32'd0} + {32'd0, ppk_q[2], 32'd0}
                + {ppk_q[3], 64'd0};
  assign prod_m = {64'd0, ppm_q[0]} + {32'd0, ppm_q[1], 32'd0} + {32'd0, ppm_q[2], 32'd0}
                + {ppm_q[3], 64'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pk_q     <= pk_full[63:0];
      pm_q     <= pm_full[63:0];
      ppk_q[0] <= 64'(pk_q[31:0]) * 64'(INV_TWO_PI_Q64[31:0]);
      ppk_q[1] <= 64'(pk_q[31:0]) * 64'(INV_TWO_PI_Q64[63:32]);
      ppk_q[2] <= 64'(pk_q[63:32]) * 64'(INV_TWO_PI_Q64[31:0]);
      ppk_q[3] <= 64'(pk_q[63:32]) * 64'(INV_TWO_PI_Q64[63:32]);
      ppm_q[0] <= 64'(pm_q[31:0]) * 64'(LOG2E_Q60[31:0]);
      ppm_q[1] <= 64'(pm_q[31:0]) * 64'(LOG2E_Q60[63:32]);
      ppm_q[2] <= 64'(pm_q[63:32]) * 64'(LOG2E_Q60[31:0]);
      ppm_q[3] <= 64'(pm_q[63:32]) * 64'(LOG2E_Q60[63:32]);
      turn_q   <= prod_k[FB+32 +: 32];
      ip_q     <= prod_m[127:FB+60];
      fr_q     <= prod_m[FB+28 +: 32];
    end
  end

  // Octant reduction, angle in radians, and exponent split of the decay.
  logic [2:0]  oct_d;
  logic [29:0] rr_d;
  logic [61:0] xp_d;
  logic signed [E_W-1:0] e_d;
  logic [31:0] w_d, w_q;

  assign oct_d = turn_q[31:29];
  assign rr_d  = oct_d[0] ? 30'(30'h2000_0000 - 30'(turn_q[28:0])) : 30'(turn_q[28:0]);
  assign xp_d  = 62'(rr_d) * 62'(HALF_PI_Q30);

  always_comb begin
    if (!wave_imag_q[31]) begin
      if (fr_q == '0) begin
        e_d = -signed'(E_W'(ip_q));
        w_d = '0;
      end else begin
        e_d = -signed'(E_W'(ip_q)) - E_W'(1);
        w_d = 32'(-fr_q);
      end
    end else begin
      e_d = signed'(E_W'(ip_q));
      w_d = fr_q;
    end
  end

  // Values that travel alongside the arithmetic.
  logic                  co_q  [ST_SUM:ST_OUT-1];
  logic [32:0]           r_q   [ST_MUL:ST_DVN-1];
  logic [2:0]            oct_q [ST_ARG:ST_OUT-1];
  logic signed [E_W-1:0] e_q   [ST_ARG:ST_OUT-1];
  logic [31:0]           x_q   [ST_ARG:ST_SIN-1];
  logic [31:0]           x2_q  [ST_SQX:X2_END];
  logic [31:0]           y_q   [ST_SQX:Y_END];
  logic [63:0]           x2_full, y_full;

  assign x2_full = 64'(x_q[ST_ARG]) * 64'(x_q[ST_ARG]);
  assign y_full  = 64'(w_q) * 64'(LN2_Q32);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      co_q[ST_SUM] <= (sum_d == '0);
      for (int i = ST_SUM + 1; i <= ST_OUT - 1; i++) co_q[i] <= co_q[i-1];
      r_q[ST_MUL] <= rt_res_q[ST_RTN];
      for (int i = ST_MUL + 1; i <= ST_DVN - 1; i++) r_q[i] <= r_q[i-1];
      oct_q[ST_ARG] <= oct_d;
      for (int i = ST_ARG + 1; i <= ST_OUT - 1; i++) oct_q[i] <= oct_q[i-1];
      e_q[ST_ARG] <= e_d;
      for (int i = ST_ARG + 1; i <= ST_OUT - 1; i++) e_q[i] <= e_q[i-1];
      w_q <= w_d;
      x_q[ST_ARG] <= xp_d[61:30];
      for (int i = ST_ARG + 1; i <= ST_SIN - 1; i++) x_q[i] <= x_q[i-1];
      x2_q[ST_SQX] <= x2_full[61:30];
      for (int i = ST_SQX + 1; i <= X2_END; i++) x2_q[i] <= x2_q[i-1];
      y_q[ST_SQX] <= 32'(y_full[63:34]);
      for (int i = ST_SQX + 1; i <= Y_END; i++) y_q[i] <= y_q[i-1];
    end
  end

  // Horner series: each term is a product stage and a divide-by-constant stage.
  logic [31:0] ps_q [EXP_TERMS];
  logic [31:0] pc_q [EXP_TERMS];
  logic [31:0] pe_q [EXP_TERMS];
  logic [31:0] ts_q [EXP_TERMS];
  logic [31:0] tc_q [EXP_TERMS];
  logic [31:0] te_q [EXP_TERMS];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int SA = ST_HN0 + 2 * j;
    logic [31:0] ts_in, tc_in, te_in;
    logic [63:0] me;
    logic [71:0] de;
    if (j == 0) begin : g_first
      assign ts_in = Q30_ONE;
      assign tc_in = Q30_ONE;
      assign te_in = Q30_ONE;
    end else begin : g_next
      assign ts_in = ts_q[j-1];
      assign tc_in = tc_q[j-1];
      assign te_in = te_q[j-1];
    end

    assign me = 64'(y_q[SA-1]) * 64'(te_in);
    assign de = 72'(pe_q[j]) * 72'(EXP_RCP[j]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pe_q[j] <= me[61:30];
        te_q[j] <= Q30_ONE + de[70:39];
      end
    end

    if (j < TRIG_TERMS) begin : g_trig
      logic [63:0] ms, mc;
      logic [71:0] ds, dc;
      assign ms = 64'(x2_q[SA-1]) * 64'(ts_in);
      assign mc = 64'(x2_q[SA-1]) * 64'(tc_in);
      assign ds = 72'(ps_q[j]) * 72'(SIN_RCP[j]);
      assign dc = 72'(pc_q[j]) * 72'(COS_RCP[j]);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ps_q[j] <= ms[61:30];
          pc_q[j] <= mc[61:30];
          ts_q[j] <= Q30_ONE - ds[70:39];
          tc_q[j] <= Q30_ONE - dc[70:39];
        end
      end
    end else begin : g_pass
      // Trig series are done; their values ride along with the exponential.
      always_ff @(posedge clk_i) begin
        if (adv) begin
          ps_q[j] <= ts_in;
          pc_q[j] <= tc_in;
          ts_q[j] <= ps_q[j];
          tc_q[j] <= pc_q[j];
        end
      end
    end
  end

  // Sine from its series, octant mapping and the numerators mant*|trig|.
  logic [63:0] sin_full;
  logic [31:0] sin_q, cos_q, mant_q;
  logic        swap;
  logic [31:0] sinm, cosm;
  logic [63:0] numc_full, nums_full;
  logic [NUM_W-1:0] num_q [2];

  assign sin_full = 64'(x_q[ST_SIN-1]) * 64'(ts_q[EXP_TERMS-1]);
  assign swap = (oct_q[ST_NUM-1] == 3'd1) || (oct_q[ST_NUM-1] == 3'd2)
             || (oct_q[ST_NUM-1] == 3'd5) || (oct_q[ST_NUM-1] == 3'd6);
  assign sinm = swap ? cos_q : sin_q;
  assign cosm = swap ? sin_q : cos_q;
  assign numc_full = 64'(mant_q) * 64'(cosm);
  assign nums_full = 64'(mant_q) * 64'(sinm);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sin_q    <= sin_full[61:30];
      cos_q    <= tc_q[EXP_TERMS-1];
      mant_q   <= te_q[EXP_TERMS-1];
      num_q[0] <= numc_full[NUM_W-1:0];
      num_q[1] <= nums_full[NUM_W-1:0];
    end
  end

  // Restoring division by R, one quotient bit per stage; lane 0 is cosine, lane 1 sine.
  logic [33:0]      dvr_q [2][NUM_W];
  logic [NUM_W-1:0] dvn_q [2][NUM_W];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar j = 0; j < NUM_W; j++) begin : g_div
      logic [33:0]      r_in, r_sh;
      logic [NUM_W-1:0] n_in, n_sh;
      if (j == 0) begin : g_first
        assign r_in = '0;
        assign n_in = num_q[ln];
      end else begin : g_next
        assign r_in = dvr_q[ln][j-1];
        assign n_in = dvn_q[ln][j-1];
      end
      assign r_sh = {r_in[32:0], n_in[NUM_W-1]};
      assign n_sh = {n_in[NUM_W-2:0], 1'b0};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (r_sh >= 34'(r_q[ST_DV0+j-1])) begin
            dvr_q[ln][j] <= r_sh - 34'(r_q[ST_DV0+j-1]);
            dvn_q[ln][j] <= n_sh | NUM_W'(1);
          end else begin
            dvr_q[ln][j] <= r_sh;
            dvn_q[ln][j] <= n_sh;
          end
        end
      end
    end
  end

  // Output scaling, clipping and sign.
  logic signed [SH_W-1:0] shamt;
  logic [2:0]  oct_o;
  logic        cos_neg, sin_neg;
  logic [32:0] res_c, res_s;
  logic signed [31:0] real_q, imag_q;
  logic        co_o_q, sat_q;

  assign shamt   = SH_W'(e_q[ST_OUT-1]) + SH_W'(OUT_SHIFT);
  assign oct_o   = oct_q[ST_OUT-1];
  assign cos_neg = (oct_o >= 3'd2) && (oct_o <= 3'd5);
  assign sin_neg = (oct_o >= 3'd4) ^ wave_real_q[31];
  assign res_c   = scale_part(dvn_q[0][NUM_W-1], shamt, cos_neg);
  assign res_s   = scale_part(dvn_q[1][NUM_W-1], shamt, sin_neg);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      co_o_q <= co_q[ST_OUT-1];
      if (co_q[ST_OUT-1]) begin
        real_q <= '0;
        imag_q <= '0;
        sat_q  <= 1'b0;
      end else begin
        real_q <= signed'(res_c[31:0]);
        imag_q <= signed'(res_s[31:0]);
        sat_q  <= res_c[32] | res_s[32];
      end
    end
  end

  assign out_valid_o  = vld_q[ST_OUT];
  assign real_part_o  = real_q;
  assign imag_part_o  = imag_q;
  assign coincident_o = co_o_q;
  assign saturated_o  = sat_q;

endmodule

FILE: dv/hkpe_checker.sv
`timescale 1ns / 1ps

module hkpe_checker
  import hkpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [31:0] source_x_i,
  input  logic [31:0] source_y_i,
  input  logic [31:0] source_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] real_part_i,
  input  logic [31:0] imag_part_i,
  input  logic        coincident_i,
  input  logic        saturated_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        coinc;
    logic        sat;
  } kernel_t;

  localparam bit [63:0] ONE_Q30 = 64'd1 << 30;
  localparam bit [63:0] TWO_32  = 64'h1_0000_0000;

  logic [31:0] wave_re_q;
  logic [31:0] wave_im_q;
  kernel_t     expected_q[$];

  // Sine and cosine of an angle in [0, pi/4], both in Q2.30.
  function automatic void octant_trig(input bit [63:0] x, output bit [63:0] s,
                                      output bit [63:0] c);
    bit [63:0] x2;
    bit [63:0] t;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 10; k >= 2; k -= 2) t = ONE_Q30 - ((x2 * t) >> 30) / (k * (k + 1));
    s = (x * t) >> 30;
    t = ONE_Q30;
    for (int k = 9; k >= 1; k -= 2) t = ONE_Q30 - ((x2 * t) >> 30) / (k * (k + 1));
    c = t;
  endfunction

  // Power of two of a 32-bit fraction, Q2.30.
  function automatic bit [63:0] pow2_frac(input bit [63:0] w);
    bit [63:0] y;
    bit [63:0] t;
    y = ((w & 64'hFFFF_FFFF) * {32'd0, LN2_Q32}) >> 34;
    t = ONE_Q30;
    for (int k = 12; k >= 1; k--) t = ONE_Q30 + ((y * t) >> 30) / k;
    return t;
  endfunction

  // Divides by the distance, applies the exponent and clips to the output range.
  function automatic bit [31:0] scale_by_dist(input bit [63:0] num, input bit [63:0] r_len,
                                              input longint sh, input bit neg,
                                              inout bit sat);
    bit [63:0] limit;
    bit [63:0] q;
    bit [63:0] v;
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = num / r_len;
    if (q == 0) return 32'd0;
    if (sh < 0) begin
      v = (sh <= -64) ? 64'd0 : (q >> (-sh));
      if (v > limit) begin
        sat = 1'b1;
        v = limit;
      end
    end else if (sh >= 63 || q > (limit >> sh)) begin
      sat = 1'b1;
      v = limit;
    end else begin
      v = q << sh;
    end
    return neg ? 32'(TWO_32 - v) : v[31:0];
  endfunction

  // Expected kernel value for one point pair under the current wave number.
  function automatic kernel_t kernel_value(input logic [31:0] pt[6]);
    kernel_t     res;
    logic signed [33:0] dv;
    bit [32:0]   mag;
    bit [67:0]   sum_sq;
    bit [67:0]   root;
    bit [67:0]   cand;
    bit [63:0]   r_len, kr, ki, ph, mp, rr, x, s, c, sinm, cosm, ip, fr, w, mant;
    bit [127:0]  wide;
    bit [31:0]   turn;
    bit [2:0]    oct;
    bit          kr_neg, ki_neg, sin_neg, cos_neg, sat;
    longint      ex, sh;
    int          fb;
    fb = WAVE_FRAC + COORD_FRAC_BITS_DEF;
    res = '0;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      dv = $signed({{2{pt[i][31]}}, pt[i]}) - $signed({{2{pt[i+3][31]}}, pt[i+3]});
      mag = dv[33] ? 33'(-dv) : 33'(dv);
      sum_sq += 68'(mag) * 68'(mag);
    end
    if (sum_sq == 0) begin
      res.coinc = 1'b1;
      return res;
    end
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (68'd1 << b);
      if (cand * cand <= sum_sq) root = cand;
    end
    r_len = root[63:0];

    // Phase as a fraction of a turn, folded into one octant.
    kr_neg = wave_re_q[31];
    kr = kr_neg ? TWO_32 - {32'd0, wave_re_q} : {32'd0, wave_re_q};
    ph = kr * r_len;
    wide = 128'(ph) * 128'(INV_TWO_PI_Q64);
    turn = 32'(wide >> (fb + 32));
    oct = turn[31:29];
    rr = {35'd0, turn[28:0]};
    if (oct[0]) rr = 64'h2000_0000 - rr;
    x = (rr * {32'd0, HALF_PI_Q30}) >> 30;
    octant_trig(x, s, c);
    if (oct == 1 || oct == 2 || oct == 5 || oct == 6) begin
      sinm = c;
      cosm = s;
    end else begin
      sinm = s;
      cosm = c;
    end
    sin_neg = (oct >= 4) != kr_neg;
    cos_neg = (oct >= 2 && oct <= 5);

    // Exponential decay or growth split into mantissa and power of two.
    ki_neg = wave_im_q[31];
    ki = ki_neg ? TWO_32 - {32'd0, wave_im_q} : {32'd0, wave_im_q};
    mp = ki * r_len;
    wide = 128'(mp) * 128'(LOG2E_Q60);
    ip = 64'(wide >> (fb + 60));
    fr = 64'(wide >> (fb + 28)) & 64'hFFFF_FFFF;
    if (!ki_neg) begin
      if (fr == 0) begin
        ex = -longint'(ip);
        w = 0;
      end else begin
        ex = -longint'(ip) - 1;
        w = TWO_32 - fr;
      end
    end else begin
      ex = longint'(ip);
      w = fr;
    end
    mant = pow2_frac(w);
    sh = ex + OUT_FRAC_BITS_DEF + COORD_FRAC_BITS_DEF - 60;
    sat = 1'b0;
    res.re = scale_by_dist(mant * cosm, r_len, sh, cos_neg, sat);
    res.im = scale_by_dist(mant * sinm, r_len, sh, sin_neg, sat);
    res.sat = sat;
    return res;
  endfunction

  assign pending_o = expected_q.size();

  // Predict on every accepted item, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    kernel_t     exp_k;
    logic [31:0] pts[6];
    if (!rst_ni) begin
      wave_re_q <= WAVE_REAL_RST;
      wave_im_q <= WAVE_IMAG_RST;
      expected_q.delete();
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        pts = '{target_x_i, target_y_i, target_z_i, source_x_i, source_y_i, source_z_i};
        expected_q.push_back(kernel_value(pts));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, got re %h im %h", $time,
                   real_part_i, imag_part_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_k = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_k.re !== real_part_i || exp_k.im !== imag_part_i ||
              exp_k.coinc !== coincident_i || exp_k.sat !== saturated_i) begin
            $display("%0t: mismatch, expected re %h im %h coinc %b sat %b", $time,
                     exp_k.re, exp_k.im, exp_k.coinc, exp_k.sat);
            $display("%0t:           actual   re %h im %h coinc %b sat %b", $time,
                     real_part_i, imag_part_i, coincident_i, saturated_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WAVE_REAL) wave_re_q <= cfg_wdata_i;
        else if (cfg_idx_i == REG_WAVE_IMAG) wave_im_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: dv/tb_helmholtz_kernel_pair_eval.sv
`timescale 1ns / 1ps

module tb_helmholtz_kernel_pair_eval;
  import hkpe_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int PIPE_DRAIN  = 160;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_PER_PHASE = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_WAVE_REAL;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] source_x_i = '0, source_y_i = '0, source_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] real_part_o, imag_part_o;
  logic        coincident_o, saturated_o;

  int fail_count, pending, checked;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  helmholtz_kernel_pair_eval u_dut (.*);

  hkpe_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .target_x_i, .target_y_i, .target_z_i, .source_x_i, .source_y_i, .source_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .real_part_i(real_part_o), .imag_part_i(imag_part_o),
    .coincident_i(coincident_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on cycles where no item moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no traffic for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one point pair and hold it until it is accepted.
  task automatic send_pair(input logic [31:0] tx, ty, tz, sx, sy, sz);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= tx;
    target_y_i <= ty;
    target_z_i <= tz;
    source_x_i <= sx;
    source_y_i <= sy;
    source_z_i <= sz;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drop valid and wait until every prediction has been matched.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Change the wave number only with an empty pipeline.
  task automatic set_wave(input logic [31:0] re, im, input bit touch_spare);
    drain_results();
    repeat (PIPE_DRAIN) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_WAVE_REAL;
    cfg_wdata_i <= re;
    @(posedge clk_i);
    cfg_idx_i <= REG_WAVE_IMAG;
    cfg_wdata_i <= im;
    @(posedge clk_i);
    if (touch_spare) begin
      cfg_idx_i <= REG_SPARE_A;
      cfg_wdata_i <= $urandom();
      @(posedge clk_i);
      cfg_idx_i <= REG_SPARE_B;
      cfg_wdata_i <= $urandom();
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random pair: mostly close neighbors, some far apart, some coincident.
  task automatic send_random_pair();
    logic [31:0] t[3];
    logic [31:0] s[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      t[i] = $urandom();
      if (kind == 0) s[i] = t[i];
      else if (kind <= 3) s[i] = $urandom();
      else s[i] = t[i] + $signed($urandom_range(32'h0400_0000)) *
                  ($urandom_range(1) ? 1 : -1);
    end
    send_pair(t[0], t[1], t[2], s[0], s[1], s[2]);
  endtask

  initial begin
    logic [31:0] wave_re[6];
    logic [31:0] wave_im[6];
    wave_re = '{WAVE_REAL_RST, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFE67_8000, 32'h0};
    wave_im = '{WAVE_IMAG_RST, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF0_0000, 32'h0};
    wave_re[5] = $urandom();
    wave_im[5] = $urandom_range(32'h0100_0000);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs under the reset wave number.
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(0, 0, 1, 0, 0, 0);
    send_pair(32'h0100_0000, 0, 0, 0, 0, 0);
    send_pair(0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000);
    send_pair(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 0, 0, 0);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'h0032_0000, 0, 0, 32'hFFCE_0000, 0, 0);

    // Phases with different wave numbers and handshake pressure.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_wave(wave_re[ph], wave_im[ph], ph == 1);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      // Short near-origin pairs give large, often clipped, magnitudes.
      send_pair(0, 0, 0, 1, 1, 1);
      send_pair(32'h0200_0000, 0, 0, 0, 0, 0);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 2 && n == RAND_PER_PHASE / 2) drain_results();
        send_random_pair();
      end
    end

    drain_results();
    repeat (PIPE_DRAIN) @(posedge clk_i);
    $display("Sent %0d point pairs over six wave numbers and four handshake modes,", items_sent);
    $display("checked %0d kernel values including coincident and clipped cases.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
